>>> design/load_cell_center_of_pressure_top_assert.svh
// Assertion macros for the center-of-pressure top level
`ifndef LOAD_CELL_CENTER_OF_PRESSURE_TOP_ASSERT_SVH
`define LOAD_CELL_CENTER_OF_PRESSURE_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define LCCOP_AST_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define LCCOP_AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/lccop_pkg.sv
// Shared types and constants for the center-of-pressure block
`timescale 1ns / 1ps

package lccop_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int CNT_W  = QPTR_W + 1;

	localparam int DIV_STEPS = 15;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam logic [1:0] CELL_FIRST = 2'd0;
	localparam logic [1:0] CELL_LAST  = 2'd3;
	localparam logic [2:0] LAST_NONE  = 3'd7;

	localparam logic [14:0] POS_LIMIT = 15'h7FFF;

	// register indexes
	localparam logic [2:0] REG_GAIN0 = 3'd0;
	localparam logic [2:0] REG_GAIN1 = 3'd1;
	localparam logic [2:0] REG_GAIN2 = 3'd2;
	localparam logic [2:0] REG_GAIN3 = 3'd3;
	localparam logic [2:0] REG_BAND  = 3'd4;
	localparam logic [2:0] REG_PITCH = 3'd5;

	localparam logic [31:0] GAIN0_RST = 32'd10371944;
	localparam logic [31:0] GAIN1_RST = 32'd10785286;
	localparam logic [31:0] GAIN2_RST = 32'd10158634;
	localparam logic [31:0] GAIN3_RST = 32'd10239397;
	localparam logic [15:0] BAND_RST  = 16'd768;
	localparam logic [7:0]  PITCH_RST = 8'd48;

	typedef struct packed {
		logic [3:0][31:0] gain;
		logic [15:0]      band;
		logic [7:0]       pitch;
	} cfg_t;

	// one in-order sample handed from front to back
	typedef struct packed {
		logic [1:0]         cell_sel;
		logic signed [31:0] delta;
		logic               emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic               start;
		logic signed [50:0] numer;
		logic signed [41:0] denom;
	} div_req_t;

	typedef struct packed {
		logic               idle;
		logic               done;
		logic signed [15:0] quot;
	} div_rsp_t;

endpackage

>>> design/lccop_if.sv
// Sample and result channel interfaces
`timescale 1ns / 1ps

interface lccop_sample_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cell_index;
	logic signed [30:0] ratio_sample;

	modport source (output valid, cell_index, ratio_sample, input ready);
	modport sink (input valid, cell_index, ratio_sample, output ready);
endinterface

interface lccop_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [41:0] total_force;
	logic               no_load;

	modport source (output valid, pos_x, pos_y, total_force, no_load, input ready);
	modport sink (input valid, pos_x, pos_y, total_force, no_load, output ready);
endinterface

>>> design/lccop_queue.sv
// Small command queue between front and back
`timescale 1ns / 1ps

module lccop_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lccop_pkg::cmd_t       wr_cmd,
	input  logic                  pop,
	output lccop_pkg::cmd_t       rd_cmd,
	output lccop_pkg::q_status_t  stat
);

	lccop_pkg::cmd_t                 mem_q [lccop_pkg::QDEPTH];
	logic [lccop_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [lccop_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [lccop_pkg::CNT_W-1:0]     count_q;

	assign rd_cmd     = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == lccop_pkg::CNT_W'(lccop_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/lccop_front.sv
// Front end: sequence check, tare capture and delta
`timescale 1ns / 1ps

module lccop_front (
	input  logic            clk,
	input  logic            arst_n,
	lccop_sample_if.sink    sample,
	input  logic            q_full,
	output logic            q_push,
	output lccop_pkg::cmd_t q_cmd
);

	logic signed [31:0] tare_q [4];
	logic [2:0]         last_cell_q;
	logic               locked_q;

	logic               accept;
	logic               in_order;
	logic [2:0]         next_cell;
	logic signed [31:0] smp;

	assign sample.ready = !q_full;
	assign accept       = sample.valid && !q_full;
	assign smp          = 32'(sample.ratio_sample);
	assign next_cell    = last_cell_q + 3'd1;
	// "none seen" wraps to zero, so it matches no cell above zero
	assign in_order     = (sample.cell_index == lccop_pkg::CELL_FIRST) ||
	                      ({1'b0, sample.cell_index} == next_cell);

	assign q_push         = accept && in_order;
	assign q_cmd.cell_sel = sample.cell_index;
	// before lock the tare takes the sample, so the delta is zero
	assign q_cmd.delta    = locked_q ? (smp - tare_q[sample.cell_index]) : '0;
	assign q_cmd.emit     = (sample.cell_index == lccop_pkg::CELL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cell_q <= lccop_pkg::LAST_NONE;
			locked_q    <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				tare_q[i] <= '0;
			end
		end else if (accept) begin
			last_cell_q <= {1'b0, sample.cell_index};
			if (in_order) begin
				if (!locked_q) begin
					tare_q[sample.cell_index] <= smp;
				end
				if (sample.cell_index == lccop_pkg::CELL_LAST) begin
					locked_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> design/lccop_div.sv
// Serial signed divider with saturation to +/-32767
`timescale 1ns / 1ps

module lccop_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lccop_pkg::div_req_t  req,
	output lccop_pkg::div_rsp_t  rsp
);

	localparam logic [1:0] D_IDLE  = 2'd0;
	localparam logic [1:0] D_CHECK = 2'd1;
	localparam logic [1:0] D_RUN   = 2'd2;
	localparam logic [1:0] D_DONE  = 2'd3;

	logic [1:0]                    state_q;
	logic [50:0]                   rem_q;
	logic [41:0]                   den_q;
	logic [55:0]                   dsh_q;
	logic [14:0]                   quo_q;
	logic [lccop_pkg::DCNT_W-1:0]  cnt_q;
	logic                          neg_q;
	logic                          sat_q;

	logic [50:0] abs_n;
	logic [41:0] abs_d;
	logic        ge;
	logic [14:0] mag;

	assign abs_n = req.numer[50] ? 51'(-req.numer) : 51'(req.numer);
	assign abs_d = req.denom[41] ? 42'(-req.denom) : 42'(req.denom);
	assign ge    = ({5'b0, rem_q} >= dsh_q);
	assign mag   = sat_q ? lccop_pkg::POS_LIMIT : quo_q;

	assign rsp.idle = (state_q == D_IDLE);
	assign rsp.done = (state_q == D_DONE);
	assign rsp.quot = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (req.start) begin
					rem_q <= abs_n;
					den_q <= abs_d;
					neg_q <= req.numer[50] ^ req.denom[41];
				end
			end
			D_CHECK: begin
				// quotient of 2^15 or more saturates
				sat_q <= ({6'b0, rem_q[50:15]} >= den_q);
				dsh_q <= {den_q, 14'b0};
				quo_q <= '0;
			end
			D_RUN: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q[50:0];
				end
				quo_q <= {quo_q[13:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					cnt_q   <= lccop_pkg::DCNT_W'(lccop_pkg::DIV_STEPS - 1);
					state_q <= ({6'b0, rem_q[50:15]} >= den_q) ? D_DONE : D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= D_DONE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

>>> design/lccop_back.sv
// Back end: force update, sums, position and result register
`timescale 1ns / 1ps

module lccop_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lccop_pkg::cfg_t      cfg,
	input  lccop_pkg::cmd_t      head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output lccop_pkg::div_req_t  div_req,
	input  lccop_pkg::div_rsp_t  div_rsp,
	lccop_result_if.source       result
);

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_MUL   = 4'd1;
	localparam logic [3:0] B_FORCE = 4'd2;
	localparam logic [3:0] B_PAIR  = 4'd3;
	localparam logic [3:0] B_SUM   = 4'd4;
	localparam logic [3:0] B_SCALE = 4'd5;
	localparam logic [3:0] B_DXS   = 4'd6;
	localparam logic [3:0] B_DXW   = 4'd7;
	localparam logic [3:0] B_DYS   = 4'd8;
	localparam logic [3:0] B_DYW   = 4'd9;
	localparam logic [3:0] B_OUT   = 4'd10;

	logic [3:0]         state_q;
	lccop_pkg::cmd_t    cmd_q;
	logic signed [63:0] prod_q;
	logic signed [39:0] force_q [4];
	logic signed [40:0] p01_q, p23_q, p13_q, p02_q;
	logic signed [41:0] sum_q, nx_q, ny_q;
	logic signed [50:0] numx_q, numy_q;
	logic               nl_q;
	logic signed [15:0] px_q, py_q;

	logic               out_valid_q;
	logic signed [15:0] out_x_q, out_y_q;
	logic signed [41:0] out_sum_q;
	logic               out_nl_q;

	logic signed [31:0] gsel;
	logic signed [63:0] prod;
	logic signed [8:0]  pitch_s;
	logic signed [50:0] numx, numy;
	logic [41:0]        sum_mag;
	logic               out_free;

	assign gsel     = $signed(cfg.gain[cmd_q.cell_sel]);
	assign prod     = gsel * cmd_q.delta;
	assign pitch_s  = $signed({1'b0, cfg.pitch});
	assign numx     = pitch_s * nx_q;
	assign numy     = pitch_s * ny_q;
	assign sum_mag  = sum_q[41] ? 42'(-sum_q) : 42'(sum_q);
	assign out_free = !out_valid_q || result.ready;

	assign q_pop         = (state_q == B_IDLE) && !q_empty;
	assign div_req.start = (state_q == B_DXS) || (state_q == B_DYS);
	assign div_req.numer = (state_q == B_DYS) ? numy_q : numx_q;
	assign div_req.denom = sum_q;

	assign result.valid       = out_valid_q;
	assign result.pos_x       = out_x_q;
	assign result.pos_y       = out_y_q;
	assign result.total_force = out_sum_q;
	assign result.no_load     = out_nl_q;

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					cmd_q <= head;
				end
			end
			B_MUL:   prod_q <= prod;
			B_PAIR: begin
				p01_q <= 41'(force_q[0]) + 41'(force_q[1]);
				p23_q <= 41'(force_q[2]) + 41'(force_q[3]);
				p13_q <= 41'(force_q[1]) + 41'(force_q[3]);
				p02_q <= 41'(force_q[0]) + 41'(force_q[2]);
			end
			B_SUM: begin
				sum_q <= 42'(p01_q) + 42'(p23_q);
				nx_q  <= 42'(p13_q) - 42'(p02_q);
				ny_q  <= 42'(p23_q) - 42'(p01_q);
			end
			B_SCALE: begin
				numx_q <= numx;
				numy_q <= numy;
				nl_q   <= (sum_mag <= {26'b0, cfg.band});
				px_q   <= '0;
				py_q   <= '0;
			end
			B_DXW: begin
				if (div_rsp.done) begin
					px_q <= div_rsp.quot;
				end
			end
			B_DYW: begin
				if (div_rsp.done) begin
					py_q <= div_rsp.quot;
				end
			end
			B_OUT: begin
				if (out_free) begin
					out_x_q   <= px_q;
					out_y_q   <= py_q;
					out_sum_q <= sum_q;
					out_nl_q  <= nl_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, forces and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				force_q[i] <= '0;
			end
		end else begin
			if (state_q == B_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_MUL;
					end
				end
				B_MUL:   state_q <= B_FORCE;
				B_FORCE: begin
					// floor of product / 2^24
					force_q[cmd_q.cell_sel] <= prod_q[63:24];
					state_q <= cmd_q.emit ? B_PAIR : B_IDLE;
				end
				B_PAIR:  state_q <= B_SUM;
				B_SUM: begin
					for (int i = 0; i < 4; i++) begin
						force_q[i] <= '0;
					end
					state_q <= B_SCALE;
				end
				B_SCALE: begin
					state_q <= (sum_mag <= {26'b0, cfg.band}) ? B_OUT : B_DXS;
				end
				B_DXS:   state_q <= B_DXW;
				B_DXW: begin
					if (div_rsp.done) begin
						state_q <= B_DYS;
					end
				end
				B_DYS:   state_q <= B_DYW;
				B_DYW: begin
					if (div_rsp.done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> design/load_cell_center_of_pressure_top.sv
// Top level of the four-cell center-of-pressure block
//
//  channel   dir  handshake      payload
//  sample    in   valid/ready    cell_index[1:0], ratio_sample[30:0] signed
//  result    out  valid/ready    pos_x, pos_y [15:0] s, total_force[41:0] s, no_load
//  config    in   wr_en          reg_index[2:0], wr_data[31:0]
//
// Front takes a request whenever the 4-entry queue has room.
// Back handles each sample by pop, 32x32 multiply and force write; cell 3
// adds pair/sum/scale, two divisions on one shared divider and an output
// step, and most of the time of a full round of four samples goes to the
// divider. Deadband or saturated quotients finish sooner. A result waits
// in the output register while the front keeps filling the queue.
// Async active-low reset restores register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "load_cell_center_of_pressure_top_assert.svh"

module load_cell_center_of_pressure_top (
	input  logic           clk,
	input  logic           arst_n,
	lccop_sample_if.sink   sample,
	lccop_result_if.source result,
	input  logic           wr_en,
	input  logic [2:0]     reg_index,
	input  logic [31:0]    wr_data
);

	lccop_pkg::cfg_t       cfg_q;
	lccop_pkg::cmd_t       push_cmd;
	lccop_pkg::cmd_t       head_cmd;
	lccop_pkg::q_status_t  q_stat;
	lccop_pkg::div_req_t   div_req;
	lccop_pkg::div_rsp_t   div_rsp;
	logic                  q_push;
	logic                  q_pop;
	logic                  out_at_origin;

	assign out_at_origin = (result.pos_x == '0) && (result.pos_y == '0);

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain[0] <= lccop_pkg::GAIN0_RST;
			cfg_q.gain[1] <= lccop_pkg::GAIN1_RST;
			cfg_q.gain[2] <= lccop_pkg::GAIN2_RST;
			cfg_q.gain[3] <= lccop_pkg::GAIN3_RST;
			cfg_q.band    <= lccop_pkg::BAND_RST;
			cfg_q.pitch   <= lccop_pkg::PITCH_RST;
		end else if (wr_en) begin
			case (reg_index)
				lccop_pkg::REG_GAIN0: cfg_q.gain[0] <= wr_data;
				lccop_pkg::REG_GAIN1: cfg_q.gain[1] <= wr_data;
				lccop_pkg::REG_GAIN2: cfg_q.gain[2] <= wr_data;
				lccop_pkg::REG_GAIN3: cfg_q.gain[3] <= wr_data;
				lccop_pkg::REG_BAND:  cfg_q.band    <= wr_data[15:0];
				lccop_pkg::REG_PITCH: cfg_q.pitch   <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front: ordering, tare, delta
	lccop_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.q_full (q_stat.full),
		.q_push (q_push),
		.q_cmd  (push_cmd)
	);

	lccop_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.pop    (q_pop),
		.rd_cmd (head_cmd),
		.stat   (q_stat)
	);

	// back: forces, sums, position, result register
	lccop_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (head_cmd),
		.q_empty (q_stat.empty),
		.q_pop   (q_pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.result  (result)
	);

	// one divider shared by x and y
	lccop_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`LCCOP_AST_NOW(a_q_no_overflow, q_push, !q_stat.full, "push into full queue")
	`LCCOP_AST_NOW(a_div_start_idle, div_req.start, div_rsp.idle, "divider started while busy")
	`LCCOP_AST_NEXT(a_div_runs, div_req.start, !div_rsp.idle, "divider ignored start")
	`LCCOP_AST_NOW(a_noload_zero, result.valid && result.no_load, out_at_origin, "no-load off origin")

endmodule

>>> test/load_cell_center_of_pressure_top_test.sv
// Self-checking testbench for the four-cell center-of-pressure block
`timescale 1ns / 1ps

module load_cell_center_of_pressure_top_test;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 7;
	// covers the divider round plus queued non-emitting requests still in flight
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 80;
	localparam int RANDOM_PHASES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int TIMEOUT_NS    = 10_000_000;

	localparam logic [30:0] RATIO_MAX = 31'h3FFF_FFFF;
	localparam logic [30:0] RATIO_MIN = 31'h4000_0000;
	// force equals the raw delta with this gain
	localparam logic [31:0] UNIT_GAIN = 32'h0100_0000;

	typedef enum {GAINS_NOMINAL, GAINS_RANDOM, GAINS_EXTREME, GAINS_UNIT} gain_style_t;

	typedef struct packed {
		logic [1:0]  cell_id;
		logic [30:0] ratio;
	} sample_req_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [41:0] total_force;
		logic               no_load;
	} center_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [2:0]  reg_index;
	logic [31:0] wr_data;

	lccop_sample_if sample_bus ();
	lccop_result_if result_bus ();

	load_cell_center_of_pressure_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_bus),
		.result    (result_bus),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data)
	);

	// Prediction state: register mirror, tares, per-cell forces, sequence tracking
	lccop_pkg::cfg_t    cfg_now;
	logic signed [31:0] tare_q [4];
	logic signed [39:0] force_q8 [4];
	int                 last_seen;
	bit                 tares_locked;

	center_t     centers_due [$];
	sample_req_t samples_to_send [$];

	// tare values of the first full round; random samples cluster around them
	int tare_pick [4] = '{1000, -2000, 500, -250};

	int samples_queued = 0;
	int samples_taken  = 0;
	int mismatches     = 0;
	bit sample_took    = 1'b0;

	// idling control: percent chance of a burst, remaining burst lengths
	int gap_pct   = 0;
	int tx_gap    = 0;
	int rx_gap    = 0;
	int hold_left = 0;
	bit hold_go   = 1'b0;
	bit hold_done = 1'b0;

	initial begin
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Quotient of pitch*num by the total, truncated toward zero, clamped
	// symmetrically so that the most negative code never shows up.
	function automatic logic signed [15:0] scaled_position(longint num, longint total);
		longint q;
		q = (longint'(cfg_now.pitch) * num) / total;
		if (q > longint'(lccop_pkg::POS_LIMIT))
			q = longint'(lccop_pkg::POS_LIMIT);
		else if (q < -longint'(lccop_pkg::POS_LIMIT))
			q = -longint'(lccop_pkg::POS_LIMIT);
		return q[15:0];
	endfunction

	// Advance the block's state by one accepted request; a cell 3 in sequence
	// yields one expected center of pressure.
	function automatic void compute_center(logic [1:0] cell_id, logic signed [30:0] ratio);
		longint  delta;
		longint  total;
		longint  mag;
		center_t due;
		// out-of-order cell only moves the sequence marker; none seen matches nothing
		if (cell_id != lccop_pkg::CELL_FIRST && int'(cell_id) != last_seen + 1) begin
			last_seen = int'(cell_id);
			return;
		end
		if (!tares_locked)
			tare_q[cell_id] = ratio;
		delta = longint'(ratio) - longint'(tare_q[cell_id]);
		// arithmetic shift: rounds toward minus infinity
		force_q8[cell_id] = 40'((longint'(signed'(cfg_now.gain[cell_id])) * delta) >>> 24);
		last_seen = int'(cell_id);
		if (cell_id != lccop_pkg::CELL_LAST)
			return;

		total = longint'(force_q8[0]) + longint'(force_q8[1])
			+ longint'(force_q8[2]) + longint'(force_q8[3]);
		mag = (total < 0) ? -total : total;
		due.total_force = total[41:0];
		due.no_load     = (mag <= longint'(cfg_now.band));
		if (due.no_load) begin
			// inside the deadband the position is forced to the origin
			due.pos_x = '0;
			due.pos_y = '0;
		end else begin
			due.pos_x = scaled_position(longint'(force_q8[1]) + longint'(force_q8[3])
				- longint'(force_q8[0]) - longint'(force_q8[2]), total);
			due.pos_y = scaled_position(longint'(force_q8[2]) + longint'(force_q8[3])
				- longint'(force_q8[0]) - longint'(force_q8[1]), total);
		end
		centers_due.push_back(due);

		for (int k = 0; k < 4; k++)
			force_q8[k] = '0;
		tares_locked = 1'b1;
	endfunction

	// Rising edge: take accepted requests into the predictor, check results.
	always @(posedge clk) begin : monitor
		center_t want;
		sample_took = arst_n && sample_bus.valid && sample_bus.ready;
		if (sample_took) begin
			samples_taken++;
			compute_center(sample_bus.cell_index, sample_bus.ratio_sample);
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (centers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected x=%0d y=%0d total=%0d no_load=%0b",
						$time, result_bus.pos_x, result_bus.pos_y,
						result_bus.total_force, result_bus.no_load);
			end else begin
				want = centers_due.pop_front();
				if (want.pos_x !== result_bus.pos_x || want.pos_y !== result_bus.pos_y
					|| want.total_force !== result_bus.total_force
					|| want.no_load !== result_bus.no_load) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: x y total no_load: want %0d %0d %0d %0b got %0d %0d %0d %0b",
							$time, want.pos_x, want.pos_y, want.total_force, want.no_load,
							result_bus.pos_x, result_bus.pos_y,
							result_bus.total_force, result_bus.no_load);
				end
			end
		end
	end

	// Falling edge: present the next request once the current one is taken,
	// with random gaps between requests.
	always @(negedge clk) begin : request_driver
		sample_req_t req;
		if (!sample_bus.valid || sample_took) begin
			if (tx_gap != 0) begin
				sample_bus.valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (samples_to_send.size() != 0) begin
				req = samples_to_send.pop_front();
				sample_bus.cell_index   <= req.cell_id;
				sample_bus.ratio_sample <= req.ratio;
				sample_bus.valid        <= 1'b1;
				if ($urandom_range(0, 99) < gap_pct)
					tx_gap <= $urandom_range(1, 13);
			end else begin
				sample_bus.valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, armed once by the stimulus; the block has to
	// back up through its queue and stall the request channel.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Falling edge: receiver ready with random stall bursts
	always @(negedge clk) begin
		if (rx_gap != 0)
			rx_gap <= rx_gap - 1;
		else if ($urandom_range(0, 99) < gap_pct)
			rx_gap <= $urandom_range(1, 13);
		result_bus.ready <= (rx_gap == 0) && (hold_left == 0);
	end

	task automatic queue_sample(logic [1:0] cell_id, logic [30:0] ratio);
		samples_to_send.push_back({cell_id, ratio});
		samples_queued++;
	endtask

	// full in-order round, each sample given as an offset from its tare
	task automatic queue_round(int d0, int d1, int d2, int d3);
		queue_sample(lccop_pkg::CELL_FIRST, 31'(tare_pick[0] + d0));
		queue_sample(2'd1, 31'(tare_pick[1] + d1));
		queue_sample(2'd2, 31'(tare_pick[2] + d2));
		queue_sample(lccop_pkg::CELL_LAST, 31'(tare_pick[3] + d3));
	endtask

	// Mostly near-tare values so totals land around the deadband, plus wide
	// in-range values, raw 31-bit patterns and the two extremes.
	function automatic logic [30:0] pick_ratio(logic [1:0] cell_id);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 31'(tare_pick[cell_id] + int'($urandom_range(0, 2000)) - 1000);
		if (roll < 75)
			return 31'(int'($urandom_range(0, 2_000_000_000)) - 1_000_000_000);
		if (roll < 90)
			return 31'($urandom);
		return ($urandom_range(0, 1) != 0) ? RATIO_MAX : RATIO_MIN;
	endfunction

	task automatic put_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		wr_en     <= 1'b1;
		reg_index <= idx;
		wr_data   <= data;
	endtask

	// writes all six registers back to back, then updates the mirror
	task automatic program_config(lccop_pkg::cfg_t next_cfg);
		put_reg(lccop_pkg::REG_GAIN0, next_cfg.gain[0]);
		put_reg(lccop_pkg::REG_GAIN1, next_cfg.gain[1]);
		put_reg(lccop_pkg::REG_GAIN2, next_cfg.gain[2]);
		put_reg(lccop_pkg::REG_GAIN3, next_cfg.gain[3]);
		put_reg(lccop_pkg::REG_BAND, {16'd0, next_cfg.band});
		put_reg(lccop_pkg::REG_PITCH, {24'd0, next_cfg.pitch});
		@(negedge clk);
		wr_en <= 1'b0;
		cfg_now = next_cfg;
	endtask

	// Block is idle once every request is taken and every result is back;
	// then give the back end time to retire requests that emit nothing.
	task automatic drain();
		while (samples_taken != samples_queued || centers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_random_phase();
		int         n;
		int         roll;
		int         skip;
		logic [1:0] cid;
		n = 0;
		while (n < PHASE_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) begin
				// well-formed round with random content
				for (int k = 0; k < 4; k++)
					queue_sample(2'(k), pick_ratio(2'(k)));
				n += 4;
			end else if (roll < 90) begin
				// broken round: one middle cell missing
				skip = $urandom_range(1, 2);
				for (int k = 0; k < 4; k++)
					if (k != skip)
						queue_sample(2'(k), pick_ratio(2'(k)));
				n += 3;
			end else begin
				cid = 2'($urandom_range(0, 3));
				queue_sample(cid, pick_ratio(cid));
				n++;
			end
		end
	endtask

	task automatic random_phase(int p);
		lccop_pkg::cfg_t next_cfg;
		for (int k = 0; k < 4; k++) begin
			case (gain_style_t'(p % 4))
				GAINS_NOMINAL: next_cfg.gain[k] = 32'($urandom_range(9_000_000, 12_000_000));
				GAINS_RANDOM:  next_cfg.gain[k] = $urandom;
				GAINS_EXTREME: begin
					case ($urandom_range(0, 3))
						0:       next_cfg.gain[k] = 32'h7FFF_FFFF;
						1:       next_cfg.gain[k] = 32'h8000_0000;
						2:       next_cfg.gain[k] = '0;
						default: next_cfg.gain[k] = UNIT_GAIN;
					endcase
				end
				default: next_cfg.gain[k] = ($urandom_range(0, 1) != 0) ? UNIT_GAIN : -UNIT_GAIN;
			endcase
		end
		case (p)
			1:       next_cfg.band = '0;
			4:       next_cfg.band = 16'hFFFF;
			6:       next_cfg.band = 16'($urandom_range(0, 65535));
			default: next_cfg.band = 16'($urandom_range(0, 3000));
		endcase
		case (p)
			2:       next_cfg.pitch = '0;
			5:       next_cfg.pitch = 8'hFF;
			default: next_cfg.pitch = 8'($urandom_range(1, 255));
		endcase
		program_config(next_cfg);
		@(posedge clk);
		// phase 3 runs flat out; the last phase has no idling at all
		if (p == 3 || p == RANDOM_PHASES - 1)
			gap_pct = 0;
		else
			gap_pct = $urandom_range(5, 30);
		if (p == 1)
			hold_go = 1'b1;
		queue_random_phase();
		drain();
	endtask

	initial begin : stimulus
		lccop_pkg::cfg_t next_cfg;

		arst_n                  = 1'b0;
		wr_en                   = 1'b0;
		reg_index               = lccop_pkg::REG_GAIN0;
		wr_data                 = '0;
		sample_bus.valid        = 1'b0;
		sample_bus.cell_index   = '0;
		sample_bus.ratio_sample = '0;
		result_bus.ready        = 1'b0;

		// model starts from the register defaults, no tares, nothing seen
		cfg_now.gain[0] = lccop_pkg::GAIN0_RST;
		cfg_now.gain[1] = lccop_pkg::GAIN1_RST;
		cfg_now.gain[2] = lccop_pkg::GAIN2_RST;
		cfg_now.gain[3] = lccop_pkg::GAIN3_RST;
		cfg_now.band    = lccop_pkg::BAND_RST;
		cfg_now.pitch   = lccop_pkg::PITCH_RST;
		for (int k = 0; k < 4; k++) begin
			tare_q[k]   = '0;
			force_q8[k] = '0;
		end
		last_seen    = int'(lccop_pkg::LAST_NONE);
		tares_locked = 1'b0;
		gap_pct      = 15;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed, reset configuration.
		// A cell 1 before anything was seen is out of order; a lone cell 0 tares
		// but is overwritten; cell 2 after cell 0 is out of order again.
		queue_sample(2'd1, 31'd123);
		queue_sample(lccop_pkg::CELL_FIRST, 31'd777);
		queue_sample(2'd2, 31'd555);
		// first full round: every sample becomes its tare, total is zero
		queue_round(0, 0, 0, 0);
		// tares now locked: sample extremes on both signs
		queue_sample(lccop_pkg::CELL_FIRST, RATIO_MAX);
		queue_sample(2'd1, RATIO_MAX);
		queue_sample(2'd2, RATIO_MIN);
		queue_sample(lccop_pkg::CELL_LAST, RATIO_MIN);
		queue_sample(lccop_pkg::CELL_FIRST, RATIO_MIN);
		queue_sample(2'd1, RATIO_MIN);
		queue_sample(2'd2, RATIO_MIN);
		queue_sample(lccop_pkg::CELL_LAST, RATIO_MIN);
		drain();

		// Directed, unit gains so each force is its raw delta.
		next_cfg.gain  = {UNIT_GAIN, UNIT_GAIN, UNIT_GAIN, UNIT_GAIN};
		next_cfg.band  = 16'd800;
		next_cfg.pitch = 8'hFF;
		program_config(next_cfg);
		@(posedge clk);
		// small total with a wide spread: x clamps high, y clamps low
		queue_round(0, 100500, -99500, 0);
		// total right on the deadband edge, then just past it on the negative side
		queue_round(800, 0, 0, 0);
		queue_round(-801, 0, 0, 0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p);

		if (mismatches == 0)
			$display("load_cell_center_of_pressure_top_test: done, clean");
		else
			$display("load_cell_center_of_pressure_top_test: done, errors");
		$finish;
	end

	// hard stop far beyond the slowest legal run
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("load_cell_center_of_pressure_top_test: done, errors");
		$finish;
	end

endmodule

>>> load_cell_center_of_pressure_top.f
+incdir+design
design/lccop_pkg.sv
design/lccop_if.sv
design/lccop_queue.sv
design/lccop_front.sv
design/lccop_div.sv
design/lccop_back.sv
design/load_cell_center_of_pressure_top.sv
test/load_cell_center_of_pressure_top_test.sv
